[sv/room_line_coordinate_parser_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the room line coordinate parser
// Same-cycle and next-cycle implication checks, gated by reset.
// ---------------------------------------------------------------------------
`ifndef ROOM_LINE_COORDINATE_PARSER_CORE_ASSERT_SVH
`define ROOM_LINE_COORDINATE_PARSER_CORE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define RLCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define RLCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rlcp_pkg.sv]
// ---------------------------------------------------------------------------
// rlcp_pkg
// Types and constants shared by the room line coordinate parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlcp_pkg;

   localparam int NAME_LEN_W = 16;
   localparam int COORD_W    = 32;
   localparam int COUNT_W    = 32;

   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_END   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BOTH    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_VT    = 8'd11;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   // largest magnitude / 10, and the last digit allowed on top of it for a negative value
   localparam logic [COORD_W-1:0] ACC_LIMIT  = 32'd214748364;
   localparam logic [3:0]         LAST_DIGIT = 4'd8;
   localparam logic [3:0]         SIG_FULL   = 4'd10;
   localparam logic [3:0]         SIG_OVER   = 4'd11;

   typedef enum logic [2:0] {
      PH_NAME0  = 3'd0,
      PH_NAME   = 3'd1,
      PH_X_WS   = 3'd2,
      PH_X_SIGN = 3'd3,
      PH_X_DIG  = 3'd4,
      PH_Y_WS   = 3'd5,
      PH_Y_SIGN = 3'd6,
      PH_Y_DIG  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_COORD = 2'd1,
      ERR_ENDED = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      MARK_NONE    = 2'd0,
      MARK_PENDING = 2'd1,
      MARK_USED    = 2'd2
   } mark_type;

   typedef struct packed {
      phase_type            phase;
      logic [COORD_W-1:0]   acc;
      logic [3:0]           sig;
      logic                 neg;
      logic [COORD_W-1:0]   first;
      err_type              err;
   } line_state_type;

   localparam line_state_type LINE_RESET = '{
      phase: PH_NAME0,
      acc:   '0,
      sig:   4'd1,
      neg:   1'b0,
      first: '0,
      err:   ERR_NONE
   };

endpackage

[sv/rlcp_if.sv]
// ---------------------------------------------------------------------------
// rlcp_if
// Valid/ready channels for line bytes in and line results out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rlcp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] char_byte;
   logic       last;

   modport source (output valid, mode, char_byte, last, input ready);
   modport sink   (input valid, mode, char_byte, last, output ready);
endinterface

interface rlcp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [1:0]                          room_kind;
   logic [rlcp_pkg::NAME_LEN_W-1:0]     name_length;
   logic signed [rlcp_pkg::COORD_W-1:0] x_coord;
   logic signed [rlcp_pkg::COORD_W-1:0] y_coord;
   logic [rlcp_pkg::COUNT_W-1:0]        rooms_seen;

   modport source (output valid, status, room_kind, name_length, x_coord, y_coord,
                   rooms_seen, input ready);
   modport sink   (input valid, status, room_kind, name_length, x_coord, y_coord,
                   rooms_seen, output ready);
endinterface

[sv/rlcp_line_step.sv]
// ---------------------------------------------------------------------------
// rlcp_line_step
// Next line-parse state for one character: name scan, blanks, sign, digits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlcp_line_step #(
   parameter int IDX_W = 16
) (
   input  rlcp_pkg::line_state_type cur,
   input  logic [IDX_W-1:0]         cur_idx,
   input  logic [7:0]               char_byte,
   output rlcp_pkg::line_state_type nxt,
   output logic [IDX_W-1:0]         nxt_idx
);

   localparam logic [IDX_W-1:0] IDX_MAX = '1;

   logic                             is_x;
   logic                             is_ws;
   logic                             is_dig_phase;
   logic                             blank;
   logic                             digit;
   logic [3:0]                       dval;
   logic [rlcp_pkg::COORD_W-1:0]     acc_next;
   logic                             overflow;

   always_comb begin
      is_x  = (cur.phase == rlcp_pkg::PH_X_WS) || (cur.phase == rlcp_pkg::PH_X_SIGN) ||
              (cur.phase == rlcp_pkg::PH_X_DIG);
      is_ws = (cur.phase == rlcp_pkg::PH_X_WS) || (cur.phase == rlcp_pkg::PH_Y_WS);
      is_dig_phase = (cur.phase == rlcp_pkg::PH_X_DIG) || (cur.phase == rlcp_pkg::PH_Y_DIG);
      blank = char_byte inside {rlcp_pkg::CH_SPACE, rlcp_pkg::CH_TAB, rlcp_pkg::CH_CR,
                                rlcp_pkg::CH_VT, rlcp_pkg::CH_FF};
      digit = char_byte inside {[rlcp_pkg::CH_ZERO:rlcp_pkg::CH_NINE]};
      dval  = char_byte[3:0];
      acc_next = {cur.acc[rlcp_pkg::COORD_W-4:0], 3'b000}
               + {cur.acc[rlcp_pkg::COORD_W-2:0], 1'b0}
               + rlcp_pkg::COORD_W'(dval);
      overflow = (cur.acc > rlcp_pkg::ACC_LIMIT) ||
                 ((cur.acc == rlcp_pkg::ACC_LIMIT) &&
                  ((dval > rlcp_pkg::LAST_DIGIT) ||
                   ((dval == rlcp_pkg::LAST_DIGIT) && !cur.neg)));
   end

   always_comb begin
      nxt     = cur;
      nxt_idx = cur_idx;
      if (cur.err == rlcp_pkg::ERR_NONE) begin
         if (char_byte == rlcp_pkg::CH_NUL) begin
            nxt.err = rlcp_pkg::ERR_ENDED;
         end else begin
            case (cur.phase)
               rlcp_pkg::PH_NAME0: begin
                  nxt_idx   = IDX_W'(1);
                  nxt.phase = rlcp_pkg::PH_NAME;
               end
               rlcp_pkg::PH_NAME: begin
                  if (char_byte == rlcp_pkg::CH_SPACE) begin
                     nxt.phase = rlcp_pkg::PH_X_WS;
                  end else if (cur_idx != IDX_MAX) begin
                     nxt_idx = cur_idx + IDX_W'(1);
                  end
               end
               default: begin
                  if (is_ws && blank) begin
                     nxt = cur;
                  end else if (is_ws && ((char_byte == rlcp_pkg::CH_PLUS) ||
                                         (char_byte == rlcp_pkg::CH_MINUS))) begin
                     nxt.neg   = (char_byte == rlcp_pkg::CH_MINUS);
                     nxt.phase = is_x ? rlcp_pkg::PH_X_SIGN : rlcp_pkg::PH_Y_SIGN;
                  end else if (digit) begin
                     if ((cur.sig >= rlcp_pkg::SIG_OVER) ||
                         ((cur.sig == rlcp_pkg::SIG_FULL) && overflow)) begin
                        nxt.err = rlcp_pkg::ERR_COORD;
                     end else begin
                        nxt.acc = acc_next;
                        if (acc_next != '0) begin
                           nxt.sig = cur.sig + 4'd1;
                        end
                        nxt.phase = is_x ? rlcp_pkg::PH_X_DIG : rlcp_pkg::PH_Y_DIG;
                     end
                  end else if ((char_byte == rlcp_pkg::CH_SPACE) && is_dig_phase) begin
                     if (is_x) begin
                        nxt.first = cur.neg ? (rlcp_pkg::COORD_W'(0) - cur.acc) : cur.acc;
                        nxt.acc   = '0;
                        nxt.sig   = 4'd1;
                        nxt.neg   = 1'b0;
                        nxt.phase = rlcp_pkg::PH_Y_WS;
                     end else begin
                        nxt.err = rlcp_pkg::ERR_ENDED;
                     end
                  end else begin
                     nxt.err = rlcp_pkg::ERR_COORD;
                  end
               end
            endcase
         end
      end
   end

endmodule

[sv/room_line_coordinate_parser_core.sv]
// ---------------------------------------------------------------------------
// room_line_coordinate_parser_core
// Parses "name x y" room lines byte by byte and reports one result per line.
// ---------------------------------------------------------------------------
// Takes one item per clock unless a final byte waits on a stalled result: an
// input register holds the byte, and the parse step and end-of-line evaluation
// sit between it and the result register, which loads when a final byte moves
// on. Marker items and non-final bytes give no result. A stalled result holds
// the result register; the input register takes no-result items meanwhile.
`timescale 1ns / 1ps

`include "room_line_coordinate_parser_core_assert.svh"

module room_line_coordinate_parser_core #(
   parameter int NAME_LEN_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   rlcp_req_if.sink          req_bus,
   rlcp_rsp_if.source        rsp_bus,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int IDX_W = (NAME_LEN_BITS < rlcp_pkg::NAME_LEN_W) ?
                          NAME_LEN_BITS : rlcp_pkg::NAME_LEN_W;

   logic                             s1_valid_ff, s1_valid_in;
   logic [1:0]                       s1_mode_ff;
   logic [7:0]                       s1_char_ff;
   logic                             s1_last_ff;

   logic                             coords_off_ff;
   rlcp_pkg::mark_type               start_ff, start_in;
   rlcp_pkg::mark_type               end_ff, end_in;
   logic [rlcp_pkg::COUNT_W-1:0]     count_ff, count_in;
   rlcp_pkg::line_state_type         line_ff, line_in, line_nxt;
   logic [IDX_W-1:0]                 idx_ff, idx_in, idx_nxt;

   logic                             out_valid_ff, out_valid_in;
   logic [1:0]                       status_ff, status_in;
   logic [1:0]                       kind_ff, kind_in;
   logic [rlcp_pkg::NAME_LEN_W-1:0]  nlen_ff, nlen_in;
   logic [rlcp_pkg::COORD_W-1:0]     x_ff, x_in;
   logic [rlcp_pkg::COORD_W-1:0]     y_ff, y_in;
   logic [rlcp_pkg::COUNT_W-1:0]     rooms_ff, rooms_in;

   logic                             s1_has_rsp;
   logic                             out_free;
   logic                             s1_go;
   logic                             both_pending;

   rlcp_line_step #(
      .IDX_W (IDX_W)
   ) u_step (
      .cur       (line_ff),
      .cur_idx   (idx_ff),
      .char_byte (s1_char_ff),
      .nxt       (line_nxt),
      .nxt_idx   (idx_nxt)
   );

   assign s1_has_rsp = s1_valid_ff && (s1_mode_ff == rlcp_pkg::MODE_BYTE) && s1_last_ff;
   assign out_free   = !out_valid_ff || rsp_bus.ready;
   assign s1_go      = s1_valid_ff && (!s1_has_rsp || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign both_pending  = (start_ff == rlcp_pkg::MARK_PENDING) &&
                          (end_ff == rlcp_pkg::MARK_PENDING);

   always_comb begin
      s1_valid_in = req_bus.ready ? req_bus.valid : s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (s1_go && s1_has_rsp) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      start_in  = start_ff;
      end_in    = end_ff;
      count_in  = count_ff;
      line_in   = line_ff;
      idx_in    = idx_ff;
      status_in = rlcp_pkg::STATUS_OK;
      kind_in   = rlcp_pkg::KIND_NORMAL;
      nlen_in   = '0;
      x_in      = '0;
      y_in      = '0;
      rooms_in  = count_ff;
      if (s1_go) begin
         case (s1_mode_ff)
            rlcp_pkg::MODE_START: start_in = rlcp_pkg::MARK_PENDING;
            rlcp_pkg::MODE_END:   end_in   = rlcp_pkg::MARK_PENDING;
            rlcp_pkg::MODE_BYTE: begin
               line_in = line_nxt;
               idx_in  = idx_nxt;
               if (s1_last_ff) begin
                  line_in = rlcp_pkg::LINE_RESET;
                  idx_in  = '0;
                  if (both_pending) begin
                     status_in = rlcp_pkg::STATUS_BOTH;
                  end else begin
                     if (end_ff == rlcp_pkg::MARK_PENDING) begin
                        kind_in = rlcp_pkg::KIND_END;
                        end_in  = rlcp_pkg::MARK_USED;
                     end
                     if (start_ff == rlcp_pkg::MARK_PENDING) begin
                        if (end_ff != rlcp_pkg::MARK_PENDING) begin
                           kind_in = rlcp_pkg::KIND_START;
                        end
                        start_in = rlcp_pkg::MARK_USED;
                     end
                     if (count_ff != '1) begin
                        count_in = count_ff + rlcp_pkg::COUNT_W'(1);
                     end
                     rooms_in = count_in;
                     nlen_in  = rlcp_pkg::NAME_LEN_W'(idx_nxt);
                     if (line_nxt.phase inside {rlcp_pkg::PH_NAME0, rlcp_pkg::PH_NAME}) begin
                        status_in = rlcp_pkg::STATUS_INVALID;
                     end else if (coords_off_ff) begin
                        status_in = rlcp_pkg::STATUS_OK;
                     end else if ((line_nxt.err == rlcp_pkg::ERR_COORD) ||
                                  (line_nxt.phase != rlcp_pkg::PH_Y_DIG)) begin
                        status_in = rlcp_pkg::STATUS_INVALID;
                     end else begin
                        x_in = line_nxt.first;
                        y_in = line_nxt.neg ? (rlcp_pkg::COORD_W'(0) - line_nxt.acc)
                                            : line_nxt.acc;
                     end
                  end
               end
            end
            default: start_in = start_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         coords_off_ff <= 1'b0;
         start_ff      <= rlcp_pkg::MARK_NONE;
         end_ff        <= rlcp_pkg::MARK_NONE;
         count_ff      <= '0;
         line_ff       <= rlcp_pkg::LINE_RESET;
         idx_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            coords_off_ff <= csr_wr_data;
         end
         start_ff <= start_in;
         end_ff   <= end_in;
         count_ff <= count_in;
         line_ff  <= line_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         s1_mode_ff <= req_bus.mode;
         s1_char_ff <= req_bus.char_byte;
         s1_last_ff <= req_bus.last;
      end
      if (s1_go && s1_has_rsp) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         nlen_ff   <= nlen_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         rooms_ff  <= rooms_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.room_kind   = kind_ff;
   assign rsp_bus.name_length = nlen_ff;
   assign rsp_bus.x_coord     = x_ff;
   assign rsp_bus.y_coord     = y_ff;
   assign rsp_bus.rooms_seen  = rooms_ff;

   `RLCP_ASSERT_NEXT(a_rsp_loaded, clock, reset, s1_go && s1_has_rsp, out_valid_ff,
      "final byte gave no result")
   `RLCP_ASSERT_NEXT(a_both_no_count, clock, reset, s1_go && s1_has_rsp && both_pending,
      count_ff == $past(count_ff), "room counted with both markers pending")
   `RLCP_ASSERT_NOW(a_count_mono, clock, reset, !$past(reset),
      count_ff >= $past(count_ff), "room count went down")
   `RLCP_ASSERT_NOW(a_bad_zero, clock, reset,
      out_valid_ff && (status_ff != rlcp_pkg::STATUS_OK),
      (x_ff == '0) && (y_ff == '0), "coordinates not zero on bad status")

endmodule
